// ===== rtl/sabr_pkg.sv =====
// Shared types and codes for the seekable audio block ring.
package sabr_pkg;

    localparam int META_CW = 17;

    typedef enum logic [2:0] {
        CMD_SEEK       = 3'd0,
        CMD_FILL_START = 3'd1,
        CMD_FILL_SMP   = 3'd2,
        CMD_PLAY       = 3'd3,
        CMD_DISCARD    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        REG_SRC_LEN    = 2'd0,
        REG_LOOP_START = 2'd1,
        REG_LOOP_END   = 2'd2,
        REG_LOOP_EN    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [39:0]        start;
        logic [31:0]        gen;
        logic [META_CW-1:0] count;
    } t_meta;

endpackage

// ===== rtl/sabr_store.sv =====
// Slot descriptor memory and sample memory, one write and one registered read each.
module sabr_store import sabr_pkg::*; #(
    parameter int NUM_SLOTS    = 16,
    parameter int SLOT_SAMPLES = 1024,
    parameter int SB           = $clog2(NUM_SLOTS),
    parameter int AW           = $clog2(NUM_SLOTS * SLOT_SAMPLES)
) (
    input  logic          i_clk,
    input  logic          i_meta_we,
    input  logic [SB-1:0] i_meta_waddr,
    input  t_meta         i_meta_wdata,
    input  logic [SB-1:0] i_meta_raddr,
    output t_meta         o_meta_rdata,
    input  logic          i_smp_we,
    input  logic [AW-1:0] i_smp_waddr,
    input  logic [63:0]   i_smp_wdata,
    input  logic [AW-1:0] i_smp_raddr,
    output logic [63:0]   o_smp_rdata
);

    t_meta       meta_mem [NUM_SLOTS];
    logic [63:0] smp_mem  [NUM_SLOTS * SLOT_SAMPLES];

    always_ff @(posedge i_clk) begin
        if (i_meta_we) begin
            meta_mem[i_meta_waddr] <= i_meta_wdata;
        end
        o_meta_rdata <= meta_mem[i_meta_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_smp_we) begin
            smp_mem[i_smp_waddr] <= i_smp_wdata;
        end
        o_smp_rdata <= smp_mem[i_smp_raddr];
    end

endmodule

// ===== rtl/seekable_audio_block_ring.sv =====
// Top level of the seekable audio block ring: control sequencer and ports.
//
//  channel  | handshake                  | payload
//  input    | i_in_valid / o_in_ready    | command, position, bound, samples, buffer_start
//  output   | o_out_valid / i_out_ready  | samples, flags, fetch answer, ui position, total
//  config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One item at a time. Seek, fill sample, unused: straight to S_FIN. Fill start: S_FS1 if
// the bound passes, then S_FS2 unless the ring is full. Play: S_PNORM, S_PMETA when a
// slot is checked, S_PDATA when a sample is read, back to S_PNORM per dropped slot;
// discard: S_DCHK, S_DMETA, again per dropped slot. The registered slot descriptor
// read sets the loop step. Reset is synchronous; the memories need no clearing. A
// result waits in the output register; the next transfer is taken while it waits.
module seekable_audio_block_ring import sabr_pkg::*; #(
    parameter int NUM_SLOTS    = 16,
    parameter int SLOT_SAMPLES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [39:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [39:0] i_position,
    input  logic [31:0] i_generation_bound,
    input  logic [31:0] i_left_in,
    input  logic [31:0] i_right_in,
    input  logic        i_buffer_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_left_out,
    output logic [31:0] o_right_out,
    output logic        o_starved,
    output logic        o_at_end,
    output logic [39:0] o_fetch_position,
    output logic [$clog2(SLOT_SAMPLES+1)-1:0] o_fetch_count,
    output logic [39:0] o_ui_position,
    output logic [31:0] o_starve_total
);

    localparam int SB = $clog2(NUM_SLOTS);
    localparam int PW = $clog2(2 * NUM_SLOTS);
    localparam int OW = $clog2(SLOT_SAMPLES);
    localparam int CW = $clog2(SLOT_SAMPLES + 1);
    localparam int AW = $clog2(NUM_SLOTS * SLOT_SAMPLES);

    typedef enum logic [3:0] {
        S_IDLE, S_FS1, S_FS2, S_PNORM, S_PMETA, S_PDATA, S_DCHK, S_DMETA, S_FIN
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;

    logic [39:0] r_src_len, r_loop_start, r_loop_end;
    logic        r_loop_en;

    logic [39:0] r_seek_target, r_writer_pos, r_reader_pos, r_playhead, r_p;
    logic [31:0] r_seek_gen, r_writer_gen, r_reader_gen, r_applied_gen, r_starve;
    logic [PW-1:0] r_write_ptr, r_read_ptr;
    logic [CW-1:0] r_fill_left, r_fill_cnt;
    logic [OW-1:0] r_fill_off;
    logic [39:0]   r_fill_start;
    logic          r_end_seen;

    logic [31:0] r_l, r_r;
    logic        r_st;
    logic [39:0] r_fpos;
    logic [CW-1:0] r_fcnt;

    logic          meta_we, smp_we;
    t_meta         meta_wdata, meta_rdata;
    logic [AW-1:0] smp_waddr, smp_raddr;
    logic [63:0]   smp_rdata;

    logic          loop_act, accept, publish;
    logic [SB-1:0] wslot, rslot;
    logic [PW:0]   occ;
    logic [39:0]   norm_w, norm_r, lim, n_playhead;
    logic [40:0]   n_cnt, slot_end;
    logic [31:0]   gen_diff, n_applied;
    logic [CW-1:0] meta_cnt;

    assign loop_act = r_loop_en && (r_loop_end > r_loop_start);
    assign norm_w   = (loop_act && r_writer_pos >= r_loop_end) ? r_loop_start : r_writer_pos;
    assign norm_r   = (loop_act && r_reader_pos >= r_loop_end) ? r_loop_start : r_reader_pos;
    assign lim      = (loop_act && r_p < r_loop_end && r_loop_end < r_src_len)
                    ? r_loop_end : r_src_len;
    assign n_cnt    = {1'b0, lim} - {1'b0, r_p};
    assign gen_diff = r_seek_gen - i_generation_bound;

    assign wslot = (r_write_ptr >= PW'(NUM_SLOTS)) ? SB'(r_write_ptr - PW'(NUM_SLOTS))
                                                   : SB'(r_write_ptr);
    assign rslot = (r_read_ptr >= PW'(NUM_SLOTS)) ? SB'(r_read_ptr - PW'(NUM_SLOTS))
                                                  : SB'(r_read_ptr);
    assign occ   = (r_write_ptr >= r_read_ptr)
                 ? (PW+1)'(r_write_ptr) - (PW+1)'(r_read_ptr)
                 : (PW+1)'(r_write_ptr) + (PW+1)'(2 * NUM_SLOTS) - (PW+1)'(r_read_ptr);

    assign meta_cnt = CW'(meta_rdata.count);
    assign slot_end = {1'b0, meta_rdata.start} + 41'(meta_cnt);

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    assign meta_we    = (r_state == S_FS2) && (lim > r_p);
    assign meta_wdata = '{start: r_p, gen: r_writer_gen,
                          count: META_CW'((n_cnt > 41'(SLOT_SAMPLES))
                                          ? 41'(SLOT_SAMPLES) : n_cnt)};
    assign smp_we     = accept && (i_command == CMD_FILL_SMP) && (r_fill_left != '0);
    assign smp_waddr  = AW'(wslot) * AW'(SLOT_SAMPLES) + AW'(r_fill_off);
    assign smp_raddr  = AW'(rslot) * AW'(SLOT_SAMPLES) + AW'(r_p - meta_rdata.start);

    assign publish    = (r_cmd == CMD_PLAY) || (r_cmd == CMD_DISCARD);
    assign n_applied  = publish ? r_reader_gen : r_applied_gen;
    assign n_playhead = publish ? r_reader_pos : r_playhead;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(2 * NUM_SLOTS - 1)) ? '0 : p + PW'(1);
    endfunction

    sabr_store #(
        .NUM_SLOTS    (NUM_SLOTS),
        .SLOT_SAMPLES (SLOT_SAMPLES),
        .SB           (SB),
        .AW           (AW)
    ) u_store (
        .i_clk        (i_clk),
        .i_meta_we    (meta_we),
        .i_meta_waddr (wslot),
        .i_meta_wdata (meta_wdata),
        .i_meta_raddr (rslot),
        .o_meta_rdata (meta_rdata),
        .i_smp_we     (smp_we),
        .i_smp_waddr  (smp_waddr),
        .i_smp_wdata  ({i_right_in, i_left_in}),
        .i_smp_raddr  (smp_raddr),
        .o_smp_rdata  (smp_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_len     <= '0;
            r_loop_start  <= '0;
            r_loop_end    <= '0;
            r_loop_en     <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SRC_LEN:    r_src_len    <= i_cfg_data;
                REG_LOOP_START: r_loop_start <= i_cfg_data;
                REG_LOOP_END:   r_loop_end   <= i_cfg_data;
                REG_LOOP_EN:    r_loop_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cmd         <= CMD_SEEK;
            r_seek_target <= '0;
            r_writer_pos  <= '0;
            r_reader_pos  <= '0;
            r_playhead    <= '0;
            r_seek_gen    <= '0;
            r_writer_gen  <= '0;
            r_reader_gen  <= '0;
            r_applied_gen <= '0;
            r_write_ptr   <= '0;
            r_read_ptr    <= '0;
            r_fill_left   <= '0;
            r_fill_off    <= '0;
            r_end_seen    <= 1'b0;
            r_starve      <= '0;
            o_out_valid   <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && r_state != S_FIN) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd  <= t_cmd'(i_command);
                        r_l    <= '0;
                        r_r    <= '0;
                        r_st   <= 1'b0;
                        r_fpos <= '0;
                        r_fcnt <= '0;
                        case (t_cmd'(i_command))
                            CMD_SEEK: begin
                                r_seek_target <= i_position;
                                r_seek_gen    <= r_seek_gen + 32'd1;
                                r_state       <= S_FIN;
                            end
                            CMD_FILL_START: begin
                                r_fill_left <= '0;
                                r_fill_off  <= '0;
                                if ((gen_diff - 32'd1) >= 32'h7FFF_FFFF) begin
                                    if (r_seek_gen != r_writer_gen) begin
                                        r_writer_gen <= r_seek_gen;
                                        r_writer_pos <= r_seek_target;
                                    end
                                    r_state <= S_FS1;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            CMD_FILL_SMP: begin
                                if (r_fill_left != '0) begin
                                    r_fill_left <= r_fill_left - CW'(1);
                                    if (r_fill_left == CW'(1)) begin
                                        r_writer_pos <= r_fill_start + 40'(r_fill_cnt);
                                        r_write_ptr  <= ptr_inc(r_write_ptr);
                                        r_fill_off   <= '0;
                                    end else begin
                                        r_fill_off <= r_fill_off + OW'(1);
                                    end
                                end
                                r_state <= S_FIN;
                            end
                            CMD_PLAY: begin
                                if (i_buffer_start && r_seek_gen != r_reader_gen) begin
                                    r_reader_gen <= r_seek_gen;
                                    r_reader_pos <= r_seek_target;
                                    r_end_seen   <= 1'b0;
                                end
                                r_state <= S_PNORM;
                            end
                            CMD_DISCARD: begin
                                if (r_seek_gen != r_reader_gen) begin
                                    r_reader_gen <= r_seek_gen;
                                    r_reader_pos <= r_seek_target;
                                    r_end_seen   <= 1'b0;
                                end
                                r_state <= S_DCHK;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_FS1: begin
                    r_p     <= norm_w;
                    r_state <= (occ >= (PW+1)'(NUM_SLOTS)) ? S_FIN : S_FS2;
                end
                S_FS2: begin
                    if (lim > r_p) begin
                        r_fill_start <= r_p;
                        r_fill_cnt   <= CW'(meta_wdata.count);
                        r_fill_left  <= CW'(meta_wdata.count);
                        r_fpos       <= r_p;
                        r_fcnt       <= CW'(meta_wdata.count);
                    end
                    r_state <= S_FIN;
                end
                S_PNORM: begin
                    r_p <= norm_r;
                    if (norm_r >= r_src_len) begin
                        r_reader_pos <= norm_r;
                        r_end_seen   <= 1'b1;
                        r_state      <= S_FIN;
                    end else if (occ == '0) begin
                        if (r_starve != 32'hFFFF_FFFF) r_starve <= r_starve + 32'd1;
                        r_st         <= 1'b1;
                        r_reader_pos <= norm_r + 40'd1;
                        r_state      <= S_FIN;
                    end else begin
                        r_reader_pos <= norm_r;
                        r_state      <= S_PMETA;
                    end
                end
                S_PMETA: begin
                    if (meta_rdata.gen != r_reader_gen || slot_end <= {1'b0, r_p}) begin
                        r_read_ptr <= ptr_inc(r_read_ptr);
                        r_state    <= S_PNORM;
                    end else if (meta_rdata.start > r_p) begin
                        if (r_starve != 32'hFFFF_FFFF) r_starve <= r_starve + 32'd1;
                        r_st         <= 1'b1;
                        r_reader_pos <= r_p + 40'd1;
                        r_state      <= S_FIN;
                    end else begin
                        r_reader_pos <= r_p + 40'd1;
                        if ({1'b0, r_p} + 41'd1 == slot_end) begin
                            r_read_ptr <= ptr_inc(r_read_ptr);
                        end
                        r_state <= S_PDATA;
                    end
                end
                S_PDATA: begin
                    r_l     <= smp_rdata[31:0];
                    r_r     <= smp_rdata[63:32];
                    r_state <= S_FIN;
                end
                S_DCHK: begin
                    r_state <= (occ == '0) ? S_FIN : S_DMETA;
                end
                S_DMETA: begin
                    if (meta_rdata.gen != r_reader_gen) begin
                        r_read_ptr <= ptr_inc(r_read_ptr);
                        r_state    <= S_DCHK;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!o_out_valid || i_out_ready) begin
                        r_applied_gen    <= n_applied;
                        r_playhead       <= n_playhead;
                        o_out_valid      <= 1'b1;
                        o_left_out       <= r_l;
                        o_right_out      <= r_r;
                        o_starved        <= r_st;
                        o_at_end         <= r_end_seen;
                        o_fetch_position <= r_fpos;
                        o_fetch_count    <= r_fcnt;
                        o_ui_position    <= (r_seek_gen != n_applied) ? r_seek_target
                                                                      : n_playhead;
                        o_starve_total   <= r_starve;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench for the seekable audio block ring: scoreboard-checked random and directed traffic.
module tb;
    import sabr_pkg::*;

    localparam int NSLOT = 16;
    localparam int SSMP  = 1024;
    localparam int PMOD  = 2 * NSLOT;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic        starved;
        logic        at_end;
        logic [39:0] fpos;
        logic [10:0] fcnt;
        logic [39:0] ui_pos;
        logic [31:0] starve_total;
    } t_res;

    class ring_scoreboard;
        logic [39:0] src_len, lp_start, lp_end;
        logic        lp_en;
        logic [39:0] seek_target, writer_pos, reader_pos, playhead;
        logic [31:0] seek_gen, writer_gen, reader_gen, applied_gen;
        int unsigned wptr, rptr, fill_left, fill_off;
        logic        end_seen;
        logic [31:0] starve_cnt;
        logic [39:0] s_start [NSLOT];
        logic [31:0] s_gen [NSLOT];
        int unsigned s_cnt [NSLOT];
        logic [63:0] store [NSLOT*SSMP];
        t_res        pending [$];
        int          errors;

        function new();
            src_len = 0; lp_start = 0; lp_end = 0; lp_en = 0;
            seek_target = 0; writer_pos = 0; reader_pos = 0; playhead = 0;
            seek_gen = 0; writer_gen = 0; reader_gen = 0; applied_gen = 0;
            wptr = 0; rptr = 0; fill_left = 0; fill_off = 0;
            end_seen = 0; starve_cnt = 0; errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [39:0] v);
            case (idx)
                REG_SRC_LEN:    src_len = v;
                REG_LOOP_START: lp_start = v;
                REG_LOOP_END:   lp_end = v;
                default:        lp_en = v[0];
            endcase
        endfunction

        function bit loop_on();
            return lp_en && lp_end > lp_start;
        endfunction

        function logic [39:0] wrap_pos(logic [39:0] p);
            return (loop_on() && p >= lp_end) ? lp_start : p;
        endfunction

        function int unsigned occ();
            return (wptr + PMOD - rptr) % PMOD;
        endfunction

        function void bump_starve();
            if (starve_cnt != 32'hFFFF_FFFF) starve_cnt++;
        endfunction

        function void adopt_seek();
            if (seek_gen != reader_gen) begin
                reader_gen = seek_gen;
                reader_pos = seek_target;
                end_seen = 0;
            end
        endfunction

        function void note_input(t_cmd cmd, logic [39:0] pos, logic [31:0] bound,
                                 logic [31:0] l, logic [31:0] r, logic bs);
            t_res e;
            logic [39:0] p, lim;
            logic [40:0] n;
            logic [31:0] d;
            int unsigned s;
            logic [40:0] slot_end;
            e = '0;
            case (cmd)
                CMD_SEEK: begin
                    seek_target = pos;
                    seek_gen++;
                end
                CMD_FILL_START: begin
                    fill_left = 0;
                    fill_off = 0;
                    d = seek_gen - bound;
                    if (!(d != 0 && !d[31])) begin
                        if (seek_gen != writer_gen) begin
                            writer_gen = seek_gen;
                            writer_pos = seek_target;
                        end
                        p = wrap_pos(writer_pos);
                        if (occ() < NSLOT && p < src_len) begin
                            lim = src_len;
                            if (loop_on() && p < lp_end && lp_end < src_len) lim = lp_end;
                            if (lim > p) begin
                                n = lim - p;
                                if (n > SSMP) n = SSMP;
                                s = wptr % NSLOT;
                                s_start[s] = p;
                                s_gen[s] = writer_gen;
                                s_cnt[s] = int'(n);
                                fill_left = int'(n);
                                e.fpos = p;
                                e.fcnt = n[10:0];
                            end
                        end
                    end
                end
                CMD_FILL_SMP: begin
                    if (fill_left != 0) begin
                        s = wptr % NSLOT;
                        store[s*SSMP + fill_off] = {r, l};
                        fill_off++;
                        fill_left--;
                        if (fill_left == 0) begin
                            writer_pos = s_start[s] + s_cnt[s];
                            wptr = (wptr + 1) % PMOD;
                            fill_off = 0;
                        end
                    end
                end
                CMD_PLAY: begin
                    if (bs) adopt_seek();
                    forever begin
                        p = wrap_pos(reader_pos);
                        reader_pos = p;
                        if (p >= src_len) begin
                            end_seen = 1;
                            break;
                        end
                        if (occ() == 0) begin
                            bump_starve();
                            e.starved = 1;
                            reader_pos = p + 1;
                            break;
                        end
                        s = rptr % NSLOT;
                        slot_end = {1'b0, s_start[s]} + s_cnt[s];
                        if (s_gen[s] != reader_gen || slot_end <= {1'b0, p}) begin
                            rptr = (rptr + 1) % PMOD;
                            continue;
                        end
                        if (s_start[s] > p) begin
                            bump_starve();
                            e.starved = 1;
                            reader_pos = p + 1;
                            break;
                        end
                        {e.right, e.left} = store[s*SSMP + (p - s_start[s])];
                        reader_pos = p + 1;
                        if (p - s_start[s] + 1 == s_cnt[s]) rptr = (rptr + 1) % PMOD;
                        break;
                    end
                    playhead = reader_pos;
                    applied_gen = reader_gen;
                end
                CMD_DISCARD: begin
                    adopt_seek();
                    while (occ() != 0 && s_gen[rptr % NSLOT] != reader_gen)
                        rptr = (rptr + 1) % PMOD;
                    playhead = reader_pos;
                    applied_gen = reader_gen;
                end
                default: ;
            endcase
            e.at_end = end_seen;
            e.ui_pos = (seek_gen != applied_gen) ? seek_target : playhead;
            e.starve_total = starve_cnt;
            pending.push_back(e);
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.left != e.left) begin
                $display("%0t: left exp %h got %h", $time, e.left, got.left); errors++;
            end
            if (got.right != e.right) begin
                $display("%0t: right exp %h got %h", $time, e.right, got.right); errors++;
            end
            if (got.starved != e.starved) begin
                $display("%0t: starved exp %0d got %0d", $time, e.starved, got.starved);
                errors++;
            end
            if (got.at_end != e.at_end) begin
                $display("%0t: at_end exp %0d got %0d", $time, e.at_end, got.at_end); errors++;
            end
            if (got.fpos != e.fpos) begin
                $display("%0t: fetch_pos exp %h got %h", $time, e.fpos, got.fpos); errors++;
            end
            if (got.fcnt != e.fcnt) begin
                $display("%0t: fetch_cnt exp %0d got %0d", $time, e.fcnt, got.fcnt); errors++;
            end
            if (got.ui_pos != e.ui_pos) begin
                $display("%0t: ui_pos exp %h got %h", $time, e.ui_pos, got.ui_pos); errors++;
            end
            if (got.starve_total != e.starve_total) begin
                $display("%0t: starve_total exp %0d got %0d", $time, e.starve_total,
                         got.starve_total);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = 0;
    logic [39:0] i_cfg_data = 0;
    logic        i_in_valid = 0, o_in_ready;
    logic [2:0]  i_command = 0;
    logic [39:0] i_position = 0;
    logic [31:0] i_generation_bound = 0, i_left_in = 0, i_right_in = 0;
    logic        i_buffer_start = 0;
    logic        o_out_valid, i_out_ready = 0;
    logic [31:0] o_left_out, o_right_out, o_starve_total;
    logic        o_starved, o_at_end;
    logic [39:0] o_fetch_position, o_ui_position;
    logic [10:0] o_fetch_count;

    ring_scoreboard sb = new();
    int send_idle = 0, recv_stall = 0, n_sent = 0;
    logic [31:0] bound_hold = 32'hFFFF_FFFF;

    seekable_audio_block_ring u_top (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result({o_left_out, o_right_out, o_starved, o_at_end,
                             o_fetch_position, o_fetch_count, o_ui_position,
                             o_starve_total});
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_input(t_cmd'(i_command), i_position, i_generation_bound,
                          i_left_in, i_right_in, i_buffer_start);
        i_out_ready <= ($urandom_range(99) >= recv_stall);
    end

    // valid stays high after a transfer until a later send's idle gap, fill_block or drain lowers it
    task automatic send(t_cmd cmd, logic [39:0] pos, logic [31:0] bound,
                        logic [31:0] l, logic [31:0] r, logic bs);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_command <= cmd;
        i_position <= pos;
        i_generation_bound <= bound;
        i_left_in <= l;
        i_right_in <= r;
        i_buffer_start <= bs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [39:0] v);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        i_cfg_we <= 0;
    endtask

    task automatic setup(logic [39:0] len, logic [39:0] ls, logic [39:0] le, logic en);
        drain();
        write_reg(REG_SRC_LEN, len);
        write_reg(REG_LOOP_START, ls);
        write_reg(REG_LOOP_END, le);
        write_reg(REG_LOOP_EN, en);
    endtask

    task automatic fill_block(int cut);
        int n;
        send(CMD_FILL_START, 0, bound_hold, 0, 0, 0);
        i_in_valid <= 0;
        #1;
        n = sb.fill_left;
        if (cut > 0 && cut < n) n = cut;
        @(posedge i_clk);
        repeat (n) send(CMD_FILL_SMP, 0, 0, $urandom, $urandom, 0);
    endtask

    task automatic rand_item();
        int k;
        k = $urandom_range(99);
        if (k < 6)
            send(CMD_SEEK, ($urandom_range(3) == 0) ? {$urandom, $urandom} :
                 $urandom_range(300), 0, 0, 0, 0);
        else if (k < 14)
            send(CMD_FILL_START, 0, ($urandom_range(9) == 0) ? $urandom :
                 sb.seek_gen + $urandom_range(2), 0, 0, 0);
        else if (k < 55)
            send(CMD_FILL_SMP, 0, 0, $urandom, $urandom, 0);
        else if (k < 93)
            send(CMD_PLAY, 0, 0, 0, 0, $urandom_range(3) == 0);
        else if (k < 97)
            send(CMD_DISCARD, 0, 0, 0, 0, 0);
        else
            send(t_cmd'($urandom_range(7)), {$urandom, $urandom}, $urandom,
                 $urandom, $urandom, $urandom_range(1));
    endtask

    task automatic phase(int items, int si, int rs);
        send_idle = si;
        recv_stall = rs;
        repeat (items) rand_item();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: empty source, extremes, unused codes
        send(CMD_PLAY, 0, 0, 0, 0, 1);
        send(CMD_FILL_SMP, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send(t_cmd'(3'd5), 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1);
        send(t_cmd'(3'd7), 0, 0, 0, 0, 0);
        setup(40'd300, 0, 0, 0);
        send(CMD_PLAY, 0, 0, 0, 0, 0);
        fill_block(5);
        fill_block(0);
        send(CMD_PLAY, 0, 0, 0, 0, 1);
        send(CMD_SEEK, 40'hFF_FFFF_FFFF, 0, 0, 0, 0);
        send(CMD_FILL_START, 0, 0, 0, 0, 0);
        send(CMD_PLAY, 0, 0, 0, 0, 0);
        send(CMD_PLAY, 0, 0, 0, 0, 1);
        send(CMD_SEEK, 40'd1, 0, 0, 0, 0);
        send(CMD_DISCARD, 0, 0, 0, 0, 0);
        send(CMD_FILL_START, 0, 32'h8000_0000, 0, 0, 0);
        // small blocks with a loop so the ring fills
        setup(40'hFF_FFFF_FFFF, 40'd10, 40'd13, 1);
        send(CMD_SEEK, 40'd20, 0, 0, 0, 0);
        repeat (17) fill_block(0);
        repeat (6) send(CMD_PLAY, 0, 0, 0, 0, 1);
        drain();
        // random phases with send idles, receive stalls, both or neither
        phase(200, 0, 0);
        setup(40'd60, 40'd5, 40'd40, 1);
        phase(300, 56, 0);
        setup(40'd500, 40'd100, 40'd50, 1);
        phase(300, 0, 56);
        setup(40'd2000, 40'd0, 40'd30, 0);
        phase(300, 34, 34);
        setup(40'd80, 40'd70, 40'd80, 1);
        phase(350, 0, 0);
        drain();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
